/* rtl/cir_pkg.sv */
package cir_pkg;

  typedef logic signed [127:0] wide_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FEW      = 2'd1,
    ST_SINGULAR = 2'd2,
    ST_ZERO_VAR = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] x_sample;
    logic signed [31:0] y_sample;
    logic               last_sample;
  } sample_t;

  typedef struct packed {
    logic               is_cointegrated;
    logic signed [31:0] test_statistic;
    logic signed [31:0] fit_intercept;
    logic signed [31:0] fit_slope;
    status_t            status;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic               flag;
    logic signed [31:0] value;
  } sat_t;

  typedef enum logic [4:0] {
    B_IDLE, B_S1_RD, B_S1_MUL, B_S1_ACC, B_DX_SET, B_DX_CHK, B_B_SET, B_B_SAT,
    B_A_SET, B_A_SAT, B_S2_RD, B_S2_MUL, B_S2_RES, B_S2_PRD, B_S2_ACC, B_DL_SET,
    B_DD_SET, B_NDL_SET, B_V_CHK, B_NORM, B_SQRT, B_ROOT_DONE, B_SH_SET, B_SHIFT,
    B_Q_FIN, B_OUT, B_DP_M1, B_DP_W1, B_DP_M2, B_DP_W2, B_DV_S, B_DV_W
  } back_state_t;

  localparam logic signed [31:0] CRIT_RESET  = -32'sd190054;
  localparam logic [127:0]       Q_ONE       = 128'd65536;
  localparam int                 MIN_SAMPLES = 3;

endpackage

/* rtl/cir_queue.sv */
module cir_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNTW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/cir_front.sv */
module cir_front import cir_pkg::*; #(
  parameter int MAX_SAMPLES = 256,
  localparam int CW = $clog2(MAX_SAMPLES + 1),
  localparam int AW = $clog2(MAX_SAMPLES)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sample_t            sample,
  output logic               job_push,
  output logic [CW-1:0]      job_n,
  input  logic               job_full,
  input  logic               unlock,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic signed [31:0] rd_x,
  output logic signed [31:0] rd_y
);

  logic signed [31:0] x_store [MAX_SAMPLES];
  logic signed [31:0] y_store [MAX_SAMPLES];
  logic [CW-1:0]      sample_count;
  logic               lock;
  logic               accept;
  logic               room;

  assign full     = lock || job_full;
  assign accept   = push && !full;
  assign room     = sample_count < CW'(MAX_SAMPLES);
  assign job_push = accept && sample.last_sample;
  assign job_n    = room ? sample_count + CW'(1) : sample_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      lock         <= 1'b0;
    end else begin
      if (unlock) begin
        lock <= 1'b0;
      end
      if (accept) begin
        if (sample.last_sample) begin
          sample_count <= '0;
          lock         <= 1'b1;
        end else if (room) begin
          sample_count <= sample_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      x_store[sample_count[AW-1:0]] <= sample.x_sample;
      y_store[sample_count[AW-1:0]] <= sample.y_sample;
    end
    if (rd_en) begin
      rd_x <= x_store[rd_addr];
      rd_y <= y_store[rd_addr];
    end
  end

endmodule

/* rtl/cir_mul.sv */
module cir_mul import cir_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  wide_t              a,
  input  logic signed [63:0] b,
  output logic               done,
  output wide_t              prod
);

  logic         busy;
  logic [5:0]   cnt;
  logic [127:0] acc;
  logic [127:0] mcand;
  logic [63:0]  mplier;
  logic         neg;
  logic [127:0] acc_add;

  assign acc_add = mplier[0] ? acc + mcand : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-add over the magnitude of b, sign applied at the end
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= a[127] ? -a : a;
      mplier <= b[63] ? -b : b;
      neg    <= a[127] ^ b[63];
    end else if (busy) begin
      acc    <= acc_add;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      if (cnt == 6'd63) begin
        prod <= neg ? -acc_add : acc_add;
      end
    end
  end

endmodule

/* rtl/cir_div.sv */
module cir_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [127:0] den,
  output logic         done,
  output logic [127:0] quo
);

  logic         busy;
  logic [6:0]   cnt;
  logic [127:0] rem;
  logic [127:0] dsr;
  logic [128:0] shifted;
  logic [128:0] trial;

  assign shifted = {rem, quo[127]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (busy) begin
      if (!trial[128]) begin
        rem <= trial[127:0];
        quo <= {quo[126:0], 1'b1};
      end else begin
        rem <= shifted[127:0];
        quo <= {quo[126:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/cir_back.sv */
module cir_back import cir_pkg::*; #(
  parameter int MAX_SAMPLES = 256,
  localparam int CW = $clog2(MAX_SAMPLES + 1),
  localparam int AW = $clog2(MAX_SAMPLES)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  logic [CW-1:0]      job_n,
  output logic               job_pop,
  output logic               unlock,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic signed [31:0] rd_x,
  input  logic signed [31:0] rd_y,
  input  logic signed [31:0] crit,
  output logic               res_push,
  output result_t            res,
  input  logic               res_full
);

  back_state_t state, state_next, ret;

  logic [CW-1:0]      n;
  logic [CW-1:0]      idx;
  logic               idx_last;
  logic signed [31:0] xl, yl;
  logic signed [63:0] px2, pxy;
  wide_t              sx, sy, sxx, sxy, sl, sd, sll, sdd, sdl;
  wide_t              opa1, opa2;
  logic signed [63:0] opb1, opb2;
  wide_t              dp_acc;
  wide_t              dx, dl, dd, ndl;
  logic [127:0]       div_num, div_den;
  logic               div_neg;
  logic signed [31:0] fit_a, fit_b;
  logic               sat;
  logic signed [63:0] pbx;
  logic signed [32:0] ya;
  logic signed [31:0] r, rprev;
  logic signed [63:0] pll;
  logic signed [65:0] pdd;
  logic signed [64:0] pdl;
  logic [127:0]       nv;
  logic signed [7:0]  half, hl, hd;
  logic               root_sel;
  logic [63:0]        sq_v, sq_r, sq_bit, sq_sum;
  logic [31:0]        rl;
  logic [127:0]       den, num;
  logic signed [8:0]  sh;
  logic signed [31:0] stat;
  logic               coint;
  status_t            status;

  logic               mul_start, mul_done, div_start, div_done;
  wide_t              mul_a, mul_prod;
  logic signed [63:0] mul_b;
  logic [127:0]       div_quo;

  wide_t              sh16;
  wide_t              q_signed;
  sat_t               sat_q;
  logic signed [64:0] t_full, t_q;
  logic signed [31:0] r_sat;
  logic signed [32:0] d_val;
  logic [127:0]       q_clamp;
  logic               norm_ok;

  function automatic sat_t sat32(input wide_t v);
    sat_t s;
    if (v[127:31] == {97{v[127]}}) begin
      s.flag  = 1'b0;
      s.value = v[31:0];
    end else begin
      s.flag  = 1'b1;
      s.value = v[127] ? 32'sh80000000 : 32'sh7fffffff;
    end
    return s;
  endfunction

  cir_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  cir_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign idx_last = (idx + CW'(1)) == n;
  assign sh16     = dp_acc <<< 16;
  assign q_signed = div_neg ? -$signed(div_quo) : $signed(div_quo);
  assign sat_q    = sat32(q_signed);
  assign t_full   = 65'($signed({ya, 16'h0000})) - 65'(pbx);
  assign t_q      = (t_full >>> 16) + $signed({64'd0, t_full[64] && (t_full[15:0] != '0)});
  assign r_sat    = (t_q[64:31] == {34{t_q[64]}}) ? t_q[31:0]
                  : (t_q[64] ? 32'sh80000000 : 32'sh7fffffff);
  assign d_val    = 33'(r) - 33'(rprev);
  assign q_clamp  = (div_quo > Q_ONE) ? Q_ONE : div_quo;
  assign norm_ok  = (nv[127:62] == '0) && (nv[61:60] != 2'b00);
  assign sq_sum   = sq_r + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:      if (job_valid) begin
                     state_next = (job_n < CW'(MIN_SAMPLES)) ? B_OUT : B_S1_RD;
                   end
      B_S1_RD:     state_next = B_S1_MUL;
      B_S1_MUL:    state_next = B_S1_ACC;
      B_S1_ACC:    state_next = idx_last ? B_DX_SET : B_S1_RD;
      B_DX_SET:    state_next = B_DP_M1;
      B_DX_CHK:    state_next = (dp_acc == '0) ? B_OUT : B_DP_M1;
      B_B_SET:     state_next = B_DV_S;
      B_B_SAT:     state_next = B_DP_M1;
      B_A_SET:     state_next = B_DV_S;
      B_A_SAT:     state_next = B_S2_RD;
      B_S2_RD:     state_next = B_S2_MUL;
      B_S2_MUL:    state_next = B_S2_RES;
      B_S2_RES:    state_next = B_S2_PRD;
      B_S2_PRD:    state_next = B_S2_ACC;
      B_S2_ACC:    state_next = idx_last ? B_DL_SET : B_S2_RD;
      B_DL_SET:    state_next = B_DP_M1;
      B_DD_SET:    state_next = B_DP_M1;
      B_NDL_SET:   state_next = B_DP_M1;
      B_V_CHK:     state_next = (dl == '0 || dd == '0) ? B_OUT : B_NORM;
      B_NORM:      if (norm_ok) begin
                     state_next = B_SQRT;
                   end
      B_SQRT:      if (sq_bit == 64'd1) begin
                     state_next = B_ROOT_DONE;
                   end
      B_ROOT_DONE: state_next = root_sel ? B_DP_M1 : B_NORM;
      B_SH_SET:    state_next = B_SHIFT;
      B_SHIFT:     if (sh == '0) begin
                     state_next = B_DV_S;
                   end
      B_Q_FIN:     state_next = B_OUT;
      B_OUT:       if (!res_full) begin
                     state_next = B_IDLE;
                   end
      B_DP_M1:     state_next = B_DP_W1;
      B_DP_W1:     if (mul_done) begin
                     state_next = B_DP_M2;
                   end
      B_DP_M2:     state_next = B_DP_W2;
      B_DP_W2:     if (mul_done) begin
                     state_next = ret;
                   end
      B_DV_S:      state_next = B_DV_W;
      B_DV_W:      if (div_done) begin
                     state_next = ret;
                   end
      default:     state_next = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop   = (state == B_IDLE) && job_valid;
    rd_en     = (state == B_S1_RD) || (state == B_S2_RD);
    rd_addr   = idx[AW-1:0];
    mul_start = (state == B_DP_M1) || (state == B_DP_M2);
    mul_a     = (state == B_DP_M2) ? opa2 : opa1;
    mul_b     = (state == B_DP_M2) ? opb2 : opb1;
    div_start = (state == B_DV_S);
    res_push  = (state == B_OUT) && !res_full;
    unlock    = res_push;
    res.is_cointegrated = coint;
    res.test_statistic  = stat;
    res.fit_intercept   = fit_a;
    res.fit_slope       = fit_b;
    res.status          = status;
    res.saturated       = sat;
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: if (job_valid) begin
        n      <= job_n;
        idx    <= '0;
        sx     <= '0;
        sy     <= '0;
        sxx    <= '0;
        sxy    <= '0;
        sl     <= '0;
        sd     <= '0;
        sll    <= '0;
        sdd    <= '0;
        sdl    <= '0;
        fit_a  <= '0;
        fit_b  <= '0;
        sat    <= 1'b0;
        stat   <= '0;
        coint  <= 1'b0;
        status <= (job_n < CW'(MIN_SAMPLES)) ? ST_FEW : ST_OK;
      end
      B_S1_MUL: begin
        px2 <= rd_x * rd_x;
        pxy <= rd_x * rd_y;
        xl  <= rd_x;
        yl  <= rd_y;
      end
      B_S1_ACC: begin
        sx  <= sx + 128'(xl);
        sy  <= sy + 128'(yl);
        sxx <= sxx + 128'(px2);
        sxy <= sxy + 128'(pxy);
        idx <= idx + CW'(1);
      end
      B_DX_SET: begin
        opa1 <= sxx;
        opb1 <= $signed(64'(n));
        opa2 <= sx;
        opb2 <= sx[63:0];
        ret  <= B_DX_CHK;
      end
      B_DX_CHK: begin
        dx <= dp_acc;
        if (dp_acc == '0) begin
          status <= ST_SINGULAR;
        end
        opa1 <= sxy;
        opb1 <= $signed(64'(n));
        opa2 <= sx;
        opb2 <= sy[63:0];
        ret  <= B_B_SET;
      end
      B_B_SET: begin
        div_num <= sh16[127] ? -sh16 : sh16;
        div_den <= dx[127] ? -dx : dx;
        div_neg <= sh16[127] ^ dx[127];
        ret     <= B_B_SAT;
      end
      B_B_SAT: begin
        fit_b <= sat_q.value;
        sat   <= sat | sat_q.flag;
        opa1  <= sy <<< 16;
        opb1  <= 64'sd1;
        opa2  <= sx;
        opb2  <= 64'(sat_q.value);
        ret   <= B_A_SET;
      end
      B_A_SET: begin
        div_num <= dp_acc[127] ? -dp_acc : dp_acc;
        div_den <= 128'(n) << 16;
        div_neg <= dp_acc[127];
        ret     <= B_A_SAT;
      end
      B_A_SAT: begin
        fit_a <= sat_q.value;
        sat   <= sat | sat_q.flag;
        idx   <= '0;
      end
      B_S2_MUL: begin
        pbx <= fit_b * rd_x;
        ya  <= 33'(rd_y) - 33'(fit_a);
      end
      B_S2_RES: r <= r_sat;
      B_S2_PRD: begin
        pll <= rprev * rprev;
        pdd <= d_val * d_val;
        pdl <= d_val * rprev;
      end
      B_S2_ACC: begin
        // the first residual has no lag
        if (idx != '0) begin
          sl  <= sl + 128'(rprev);
          sd  <= sd + 128'(d_val);
          sll <= sll + 128'(pll);
          sdd <= sdd + 128'(pdd);
          sdl <= sdl + 128'(pdl);
        end
        rprev <= r;
        idx   <= idx + CW'(1);
      end
      B_DL_SET: begin
        opa1 <= sll;
        opb1 <= $signed(64'(n) - 64'd1);
        opa2 <= sl;
        opb2 <= sl[63:0];
        ret  <= B_DD_SET;
      end
      B_DD_SET: begin
        dl   <= dp_acc;
        opa1 <= sdd;
        opb1 <= $signed(64'(n) - 64'd1);
        opa2 <= sd;
        opb2 <= sd[63:0];
        ret  <= B_NDL_SET;
      end
      B_NDL_SET: begin
        dd   <= dp_acc;
        opa1 <= sdl;
        opb1 <= $signed(64'(n) - 64'd1);
        opa2 <= sd;
        opb2 <= sl[63:0];
        ret  <= B_V_CHK;
      end
      B_V_CHK: begin
        ndl <= dp_acc;
        if (dl == '0) begin
          status <= ST_SINGULAR;
        end else if (dd == '0) begin
          status <= ST_ZERO_VAR;
        end
        nv       <= dl;
        half     <= '0;
        root_sel <= 1'b0;
      end
      B_NORM: begin
        // bring the top bit to position 60 or 61, two bits a step
        if (nv[127:62] != '0) begin
          nv   <= nv >> 2;
          half <= half + 8'sd1;
        end else if (nv[61:60] == 2'b00) begin
          nv   <= nv << 2;
          half <= half - 8'sd1;
        end else begin
          sq_v   <= nv[63:0];
          sq_r   <= '0;
          sq_bit <= 64'h4000000000000000;
        end
      end
      B_SQRT: begin
        if (sq_v >= sq_sum) begin
          sq_v <= sq_v - sq_sum;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      B_ROOT_DONE: begin
        if (!root_sel) begin
          rl       <= sq_r[31:0];
          hl       <= half;
          nv       <= dd;
          half     <= '0;
          root_sel <= 1'b1;
        end else begin
          hd   <= half;
          opa1 <= 128'(rl);
          opb1 <= $signed(sq_r);
          opa2 <= '0;
          opb2 <= '0;
          ret  <= B_SH_SET;
        end
      end
      B_SH_SET: begin
        den <= dp_acc;
        num <= ndl[127] ? -ndl : ndl;
        sh  <= 9'sd16 - (9'(hl) + 9'(hd));
      end
      B_SHIFT: begin
        if (sh > 9'sd0) begin
          num <= num << 1;
          sh  <= sh - 9'sd1;
        end else if (sh < 9'sd0) begin
          num <= num >> 1;
          sh  <= sh + 9'sd1;
        end else begin
          div_num <= num;
          div_den <= den;
          div_neg <= ndl[127];
          ret     <= B_Q_FIN;
        end
      end
      B_Q_FIN: begin
        stat  <= ndl[127] ? -q_clamp[31:0] : q_clamp[31:0];
        coint <= (ndl[127] ? -$signed(q_clamp[31:0]) : $signed(q_clamp[31:0])) < crit;
      end
      B_DP_W1: if (mul_done) begin
        dp_acc <= mul_prod;
      end
      B_DP_W2: if (mul_done) begin
        dp_acc <= dp_acc - mul_prod;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/cointegration_residual_test.sv */
// residual cointegration test on paired series x and y (signed q16.16)
// sample channel: a queue input; push a pair while full is low, one per cycle.
// the pair with last_sample set closes the series and starts the test; pairs
// beyond MAX_SAMPLES are dropped, a dropped last pair still starts the test.
// result channel: a queue output; the oldest result sits on result while
// empty is low and leaves on pop. one result per series.
// after the last pair, the first pass over the store reads, multiplies and
// accumulates each pair, and the residual pass reads, multiplies, forms the
// residual, forms the lag products and accumulates each pair. normalizing for
// each square root moves two bits a step and the final shift one bit a step.
// the rest is done by the shared shift-add multiplier (14 products), the
// restoring divider (3 divisions) and the square root unit (2 roots).
// full stays high from the last pair until its result enters the two-entry
// result queue, so a stalled receiver holds the block once that queue fills.
// critical_value is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while idle, the block does not enforce it. reset empties both
// queues and the sample store and sets critical_value to -2.9; no clearing.
module cointegration_residual_test import cir_pkg::*; #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sample_t            sample,
  output logic               empty,
  input  logic               pop,
  output result_t            result,
  input  logic               cfg_wr_en,
  input  logic signed [31:0] cfg_wr_data
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int RW = $bits(result_t);

  logic signed [31:0] critical_value;
  logic               job_push, job_full, job_empty, job_pop;
  logic [CW-1:0]      job_n_in, job_n_out;
  logic               unlock;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_x, rd_y;
  logic               res_push, res_full;
  result_t            res;
  logic [RW-1:0]      res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      critical_value <= CRIT_RESET;
    end else if (cfg_wr_en) begin
      critical_value <= cfg_wr_data;
    end
  end

  cir_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .sample   (sample),
    .job_push (job_push),
    .job_n    (job_n_in),
    .job_full (job_full),
    .unlock   (unlock),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_x     (rd_x),
    .rd_y     (rd_y)
  );

  cir_queue #(.WIDTH(CW), .DEPTH(2)) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_n_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_n_out),
    .empty   (job_empty)
  );

  cir_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job_n     (job_n_out),
    .job_pop   (job_pop),
    .unlock    (unlock),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_x      (rd_x),
    .rd_y      (rd_y),
    .crit      (critical_value),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  cir_queue #(.WIDTH(RW), .DEPTH(2)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_data),
    .empty   (empty)
  );

  assign result = result_t'(res_data);

endmodule

/* rtl/cir_checker.sv */
module cir_checker import cir_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    push,
  input logic    full,
  input sample_t sample,
  input logic    empty,
  input result_t result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (push && !full && sample.last_sample) |=> full)
    else $error("input not blocked after last request");

  a_few_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_FEW) |->
    (result.test_statistic == 0 && result.fit_slope == 0 &&
     result.fit_intercept == 0 && !result.saturated))
    else $error("too-few result carries nonzero fields");

  a_coint_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.is_cointegrated) |-> (result.status == ST_OK))
    else $error("cointegrated flag with bad status");

  a_stat_clamp: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_OK) |->
    (result.test_statistic <= 32'sd65536 && result.test_statistic >= -32'sd65536))
    else $error("statistic outside unit range");

endmodule

bind cointegration_residual_test cir_checker u_chk (.*);
